// ===== rtl/core/matrix_multiply_transpose_modes_core_assert.svh =====
// Assertion macros shared by the checker of the matrix multiply core.
// Each macro samples on aclk; the reset form also checks while aresetn is low.
`ifndef MATRIX_MULTIPLY_TRANSPOSE_MODES_CORE_ASSERT_SVH
`define MATRIX_MULTIPLY_TRANSPOSE_MODES_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MMTM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MMTM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define MMTM_ASSERT_RESET(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mmtm_pkg.sv =====
// Package of the matrix multiply core: sizes, codes, and the structs that
// join the controller and the datapath. No dependencies.
`default_nettype none

package mmtm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int ELEM_BITS   = 16;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int DIM_W       = 4;
    localparam int IDX_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ROW_W       = 3;
    localparam int VAL_W       = 35;
    localparam int PROD_W      = 2 * ELEM_BITS;
    localparam int SUM_W       = ((PROD_W > VAL_W) ? PROD_W : VAL_W) + 1;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = DIM_W;
    localparam int S_TDATA_W   = ((CMD_W + ADDR_W + ELEM_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((VAL_W + 2 * ROW_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_LOAD_A  = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_LOAD_B  = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_COMPUTE = CMD_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_A_TR      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_B_TR      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_ROWS  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_A_ROW_LEN = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROW_LEN = CFG_IDX_W'(6);

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'({1'b0, {(VAL_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

    typedef struct packed {
        logic             a_tr;
        logic             b_tr;
        logic [DIM_W-1:0] out_rows;
        logic [DIM_W-1:0] out_cols;
        logic [DIM_W-1:0] inner_len;
        logic [DIM_W-1:0] a_row_len;
        logic [DIM_W-1:0] b_row_len;
    } cfg_t;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             issue;
        logic             clear;
        logic             emit;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] k;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } ctrl_stat_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        return (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/matrix_multiply_transpose_modes_core.sv =====
// Top level of the matrix multiply core with per-operand transpose flags.
// Holds the configuration registers; uses mmtm_pkg, mmtm_ctrl and mmtm_datapath.
//
// The core computes op(A) x op(B) on signed Q8.8 elements held in two local
// 64-entry stores and emits one signed Q19.16 result item per output cell in
// row-major order, with tlast on the final cell. A load item writes one store
// entry. For each output cell of a compute item, one shared multiplier-
// accumulator steps through the inner index one product a cycle, fed by one
// registered read port per store, and a cell is emitted after the product
// pipeline drains. Input items are taken one at a time; configuration is to
// be written only while the core is idle and entries read must have been
// loaded, which the core itself does not enforce.
`default_nettype none

module matrix_multiply_transpose_modes_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // Fields from bit 0: cmd, position, element.
    input  wire logic [mmtm_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // Fields from bit 0: cell_value, cell_row, cell_col, zero fill.
    output logic      [mmtm_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                      m_tlast,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [mmtm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mmtm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    mmtm_pkg::cfg_t        cfg_reg;
    mmtm_pkg::ctrl_cmd_t   cmd;
    mmtm_pkg::ctrl_stat_t  stat;

    logic [mmtm_pkg::CMD_W-1:0]      s_cmd;
    logic [mmtm_pkg::ADDR_W-1:0]     s_position;
    logic [mmtm_pkg::ELEM_BITS-1:0]  s_element;

    assign s_cmd      = s_tdata[mmtm_pkg::CMD_W-1:0];
    assign s_position = s_tdata[mmtm_pkg::CMD_W +: mmtm_pkg::ADDR_W];
    assign s_element  = s_tdata[mmtm_pkg::CMD_W + mmtm_pkg::ADDR_W +: mmtm_pkg::ELEM_BITS];
    assign cfg_ready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.a_tr      <= 1'b0;
            cfg_reg.b_tr      <= 1'b0;
            cfg_reg.out_rows  <= mmtm_pkg::DIM_W'(1);
            cfg_reg.out_cols  <= mmtm_pkg::DIM_W'(1);
            cfg_reg.inner_len <= mmtm_pkg::DIM_W'(1);
            cfg_reg.a_row_len <= mmtm_pkg::DIM_W'(1);
            cfg_reg.b_row_len <= mmtm_pkg::DIM_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mmtm_pkg::CFG_A_TR: begin
                    cfg_reg.a_tr <= cfg_data[0];
                end
                mmtm_pkg::CFG_B_TR: begin
                    cfg_reg.b_tr <= cfg_data[0];
                end
                mmtm_pkg::CFG_OUT_ROWS: begin
                    cfg_reg.out_rows <= cfg_data;
                end
                mmtm_pkg::CFG_OUT_COLS: begin
                    cfg_reg.out_cols <= cfg_data;
                end
                mmtm_pkg::CFG_INNER_LEN: begin
                    cfg_reg.inner_len <= cfg_data;
                end
                mmtm_pkg::CFG_A_ROW_LEN: begin
                    cfg_reg.a_row_len <= cfg_data;
                end
                mmtm_pkg::CFG_B_ROW_LEN: begin
                    cfg_reg.b_row_len <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    mmtm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_cmd),
        .stat     (stat),
        .cmd      (cmd)
    );

    mmtm_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .stat       (stat),
        .s_position (s_position),
        .s_element  (s_element),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mmtm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module mmtm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/mmtm_ctrl.sv =====
// Controller of the matrix multiply core: walks the output cells and the
// inner index, and sequences loads, reads and emits. Uses mmtm_pkg.
`default_nettype none

module mmtm_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire mmtm_pkg::cfg_t                cfg,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mmtm_pkg::CMD_W-1:0]    s_cmd,
    input  wire mmtm_pkg::ctrl_stat_t          stat,
    output mmtm_pkg::ctrl_cmd_t                cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_EMIT
    } state_t;

    state_t                         state_reg, state_next;
    logic [mmtm_pkg::IDX_W-1:0]     row_reg, row_next;
    logic [mmtm_pkg::IDX_W-1:0]     col_reg, col_next;
    logic [mmtm_pkg::IDX_W-1:0]     k_reg, k_next;
    logic [mmtm_pkg::DIM_W-1:0]     rows, cols, klen;
    logic                           last_k, last_c, last_r;

    always_comb begin
        rows   = mmtm_pkg::clamp_dim(cfg.out_rows);
        cols   = mmtm_pkg::clamp_dim(cfg.out_cols);
        klen   = mmtm_pkg::clamp_dim(cfg.inner_len);
        last_k = (mmtm_pkg::DIM_W'(k_reg) + mmtm_pkg::DIM_W'(1)) == klen;
        last_c = (mmtm_pkg::DIM_W'(col_reg) + mmtm_pkg::DIM_W'(1)) == cols;
        last_r = (mmtm_pkg::DIM_W'(row_reg) + mmtm_pkg::DIM_W'(1)) == rows;

        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        k_next     = k_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.row    = row_reg;
        cmd.col    = col_reg;
        cmd.k      = k_reg;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (s_cmd)
                        mmtm_pkg::CMD_LOAD_A: begin
                            cmd.wr_a = 1'b1;
                        end
                        mmtm_pkg::CMD_LOAD_B: begin
                            cmd.wr_b = 1'b1;
                        end
                        mmtm_pkg::CMD_COMPUTE: begin
                            if (rows != '0 && cols != '0) begin
                                cmd.clear  = 1'b1;
                                row_next   = '0;
                                col_next   = '0;
                                k_next     = '0;
                                state_next = ST_ISSUE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ISSUE: begin
                cmd.issue = (klen != '0);
                if (klen == '0 || last_k) begin
                    state_next = ST_WAIT;
                end else begin
                    k_next = k_reg + mmtm_pkg::IDX_W'(1);
                end
            end
            ST_WAIT: begin
                if (!stat.pipe_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                cmd.last = last_r && last_c;
                if (stat.out_free) begin
                    cmd.emit  = 1'b1;
                    cmd.clear = 1'b1;
                    k_next    = '0;
                    if (last_r && last_c) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_ISSUE;
                        if (last_c) begin
                            col_next = '0;
                            row_next = row_reg + mmtm_pkg::IDX_W'(1);
                        end else begin
                            col_next = col_reg + mmtm_pkg::IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            k_reg     <= k_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mmtm_datapath.sv =====
// Datapath of the matrix multiply core: element stores, address generation,
// the shared multiply-accumulate pipeline and the output register.
// Uses mmtm_pkg and mmtm_ram.
`default_nettype none

module mmtm_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire mmtm_pkg::cfg_t                      cfg,
    input  wire mmtm_pkg::ctrl_cmd_t                 cmd,
    output mmtm_pkg::ctrl_stat_t                     stat,
    input  wire logic [mmtm_pkg::ADDR_W-1:0]         s_position,
    input  wire logic [mmtm_pkg::ELEM_BITS-1:0]      s_element,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [mmtm_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                     m_tlast
);

    logic [mmtm_pkg::ADDR_W-1:0]           row_a, col_a, k_a;
    logic [mmtm_pkg::ADDR_W-1:0]           a_addr, b_addr;
    logic [mmtm_pkg::ELEM_BITS-1:0]        a_rd, b_rd;
    logic                                  valid1_reg, valid2_reg;
    logic signed [mmtm_pkg::PROD_W-1:0]    prod_reg;
    logic signed [mmtm_pkg::VAL_W-1:0]     acc_reg, acc_next;
    logic signed [mmtm_pkg::SUM_W-1:0]     sum;
    logic                                  out_valid_reg;
    logic signed [mmtm_pkg::VAL_W-1:0]     out_value_reg;
    logic [mmtm_pkg::ROW_W-1:0]            out_row_reg, out_col_reg;
    logic                                  out_last_reg;

    always_comb begin
        row_a = mmtm_pkg::ADDR_W'(cmd.row);
        col_a = mmtm_pkg::ADDR_W'(cmd.col);
        k_a   = mmtm_pkg::ADDR_W'(cmd.k);
        if (cfg.a_tr) begin
            a_addr = k_a * mmtm_pkg::ADDR_W'(cfg.a_row_len) + row_a;
        end else begin
            a_addr = row_a * mmtm_pkg::ADDR_W'(cfg.a_row_len) + k_a;
        end
        if (cfg.b_tr) begin
            b_addr = col_a * mmtm_pkg::ADDR_W'(cfg.b_row_len) + k_a;
        end else begin
            b_addr = k_a * mmtm_pkg::ADDR_W'(cfg.b_row_len) + col_a;
        end
    end

    mmtm_ram #(
        .WIDTH (mmtm_pkg::ELEM_BITS),
        .DEPTH (mmtm_pkg::STORE_DEPTH)
    ) u_a_ram (
        .aclk  (aclk),
        .we    (cmd.wr_a),
        .waddr (s_position),
        .wdata (s_element),
        .raddr (a_addr),
        .rdata (a_rd)
    );

    mmtm_ram #(
        .WIDTH (mmtm_pkg::ELEM_BITS),
        .DEPTH (mmtm_pkg::STORE_DEPTH)
    ) u_b_ram (
        .aclk  (aclk),
        .we    (cmd.wr_b),
        .waddr (s_position),
        .wdata (s_element),
        .raddr (b_addr),
        .rdata (b_rd)
    );

    always_comb begin
        sum = mmtm_pkg::SUM_W'(acc_reg) + mmtm_pkg::SUM_W'(prod_reg);
        if (sum > mmtm_pkg::SAT_MAX) begin
            acc_next = mmtm_pkg::VAL_W'(mmtm_pkg::SAT_MAX);
        end else if (sum < mmtm_pkg::SAT_MIN) begin
            acc_next = mmtm_pkg::VAL_W'(mmtm_pkg::SAT_MIN);
        end else begin
            acc_next = mmtm_pkg::VAL_W'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg    <= 1'b0;
            valid2_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            valid1_reg <= cmd.issue;
            valid2_reg <= valid1_reg;
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (valid1_reg) begin
            prod_reg <= signed'(a_rd) * signed'(b_rd);
        end
        if (cmd.clear) begin
            acc_reg <= '0;
        end else if (valid2_reg) begin
            acc_reg <= acc_next;
        end
        if (cmd.emit) begin
            out_value_reg <= acc_reg;
            out_row_reg   <= mmtm_pkg::ROW_W'(cmd.row);
            out_col_reg   <= mmtm_pkg::ROW_W'(cmd.col);
            out_last_reg  <= cmd.last;
        end
    end

    assign stat.pipe_busy = valid1_reg | valid2_reg;
    assign stat.out_free  = !out_valid_reg | m_tready;
    assign m_tvalid       = out_valid_reg;
    assign m_tlast        = out_last_reg;
    assign m_tdata        = mmtm_pkg::M_TDATA_W'({out_col_reg, out_row_reg, out_value_reg});

endmodule

`default_nettype wire

// ===== rtl/core/mmtm_checker.sv =====
// Port-level checker of the matrix multiply core, bound to the top level.
// Uses mmtm_pkg and the assertion macros header.
`default_nettype none

`include "matrix_multiply_transpose_modes_core_assert.svh"

module mmtm_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic [mmtm_pkg::S_TDATA_W-1:0]   s_tdata,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [mmtm_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire logic                             m_tlast
);

    logic load_accepted;

    assign load_accepted = s_tvalid && s_tready &&
        (s_tdata[mmtm_pkg::CMD_W-1:0] == mmtm_pkg::CMD_LOAD_A ||
         s_tdata[mmtm_pkg::CMD_W-1:0] == mmtm_pkg::CMD_LOAD_B);

    `MMTM_ASSERT_RESET(a_reset_clears_out, !aresetn, !m_tvalid, "result valid after reset")

    `MMTM_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    `MMTM_ASSERT_NOW(a_busy_mid_result, m_tvalid && !m_tlast, !s_tready, "input taken before the result was complete")

    `MMTM_ASSERT_NEXT(a_load_one_cycle, load_accepted, s_tready, "load item did not finish in one cycle")

endmodule

bind matrix_multiply_transpose_modes_core mmtm_checker u_checker (.*);

`default_nettype wire

// ===== bench/mmtm_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for matrix_multiply_transpose_modes_core: watches the input,
// result and register channels, predicts every cell sum and compares it.
// Depends on mmtm_pkg only.
module mmtm_result_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [mmtm_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [mmtm_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              m_tlast,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [mmtm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mmtm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                mismatches,
    output int                                sums_outstanding,
    output int                                cells_seen
);
    import mmtm_pkg::*;

    localparam longint SUM_HI = (longint'(1) <<< (VAL_W - 1)) - 1;
    localparam longint SUM_LO = -(longint'(1) <<< (VAL_W - 1));

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic             last;
    } cell_sum_t;

    cell_sum_t            cell_sums_due[$];
    logic [ELEM_BITS-1:0] a_elems[STORE_DEPTH];
    logic [ELEM_BITS-1:0] b_elems[STORE_DEPTH];
    cfg_t                 cfg_q;
    int                   miss_count = 0;
    int                   seen_count = 0;

    function automatic void queue_cell_sums();
        int        rows;
        int        cols;
        int        depth;
        int        a_at;
        int        b_at;
        longint    acc;
        cell_sum_t due;
        rows  = (cfg_q.out_rows > MAX_DIM) ? MAX_DIM : int'(cfg_q.out_rows);
        cols  = (cfg_q.out_cols > MAX_DIM) ? MAX_DIM : int'(cfg_q.out_cols);
        depth = (cfg_q.inner_len > MAX_DIM) ? MAX_DIM : int'(cfg_q.inner_len);
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                acc = 0;
                for (int k = 0; k < depth; k++) begin
                    a_at = cfg_q.a_tr ? k * cfg_q.a_row_len + r : r * cfg_q.a_row_len + k;
                    b_at = cfg_q.b_tr ? c * cfg_q.b_row_len + k : k * cfg_q.b_row_len + c;
                    acc += longint'($signed(a_elems[a_at & (STORE_DEPTH - 1)]))
                         * longint'($signed(b_elems[b_at & (STORE_DEPTH - 1)]));
                    if (acc > SUM_HI) acc = SUM_HI;
                    if (acc < SUM_LO) acc = SUM_LO;
                end
                due.value = acc[VAL_W-1:0];
                due.row   = ROW_W'(r);
                due.col   = ROW_W'(c);
                due.last  = (r == rows - 1) && (c == cols - 1);
                cell_sums_due.push_back(due);
            end
        end
    endfunction

    always @(posedge aclk) begin
        cell_sum_t got;
        cell_sum_t want;
        if (!aresetn) begin
            cfg_q = '{a_tr: 1'b0, b_tr: 1'b0, out_rows: DIM_W'(1), out_cols: DIM_W'(1),
                      inner_len: DIM_W'(1), a_row_len: DIM_W'(1), b_row_len: DIM_W'(1)};
            cell_sums_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_A_TR:      cfg_q.a_tr      = cfg_data[0];
                    CFG_B_TR:      cfg_q.b_tr      = cfg_data[0];
                    CFG_OUT_ROWS:  cfg_q.out_rows  = cfg_data;
                    CFG_OUT_COLS:  cfg_q.out_cols  = cfg_data;
                    CFG_INNER_LEN: cfg_q.inner_len = cfg_data;
                    CFG_A_ROW_LEN: cfg_q.a_row_len = cfg_data;
                    CFG_B_ROW_LEN: cfg_q.b_row_len = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                case (s_tdata[CMD_W-1:0])
                    CMD_LOAD_A:  a_elems[s_tdata[CMD_W +: ADDR_W]] =
                                     s_tdata[CMD_W + ADDR_W +: ELEM_BITS];
                    CMD_LOAD_B:  b_elems[s_tdata[CMD_W +: ADDR_W]] =
                                     s_tdata[CMD_W + ADDR_W +: ELEM_BITS];
                    CMD_COMPUTE: queue_cell_sums();
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.value = m_tdata[VAL_W-1:0];
                got.row   = m_tdata[VAL_W +: ROW_W];
                got.col   = m_tdata[VAL_W + ROW_W +: ROW_W];
                got.last  = m_tlast;
                seen_count++;
                if (cell_sums_due.size() == 0) begin
                    if (miss_count < 10)
                        $display("Unexpected result: value %0d row %0d col %0d last %0b",
                                 $signed(got.value), got.row, got.col, got.last);
                    miss_count++;
                end else begin
                    want = cell_sums_due.pop_front();
                    if (got.value !== want.value || got.row !== want.row
                            || got.col !== want.col || got.last !== want.last) begin
                        if (miss_count < 10)
                            $display({"Result mismatch: expected value %0d row %0d col %0d ",
                                      "last %0b, got value %0d row %0d col %0d last %0b"},
                                     $signed(want.value), want.row, want.col, want.last,
                                     $signed(got.value), got.row, got.col, got.last);
                        miss_count++;
                    end
                end
            end
        end
        mismatches       <= miss_count;
        sums_outstanding <= cell_sums_due.size();
        cells_seen       <= seen_count;
    end

endmodule

// ===== bench/tb_matrix_multiply_transpose_modes_core.sv =====
`timescale 1ns / 1ps
// Testbench top for matrix_multiply_transpose_modes_core: drives load, compute and
// register items with random gaps and one long result stall, then gives the verdict.
// Depends on mmtm_pkg, the core and mmtm_result_checker.
module tb_matrix_multiply_transpose_modes_core;
    import mmtm_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_UNUSED   = CMD_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = CFG_IDX_W'(7);
    localparam int                   RANDOM_ITEMS = 370;
    localparam int                   SETTLE       = 40;
    localparam int                   HOLD_CYCLES  = 400;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int sums_outstanding;
    int cells_seen;

    cfg_t setting = '{a_tr: 1'b0, b_tr: 1'b0, out_rows: DIM_W'(1), out_cols: DIM_W'(1),
                      inner_len: DIM_W'(1), a_row_len: DIM_W'(1), b_row_len: DIM_W'(1)};
    logic [STORE_DEPTH-1:0] a_loaded = '0;
    logic [STORE_DEPTH-1:0] b_loaded = '0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int holds_asked = 0;
    int holds_served = 0;
    int loads_sent = 0;
    int computes_sent = 0;
    int settings_used = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    matrix_multiply_transpose_modes_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mmtm_result_checker result_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .sums_outstanding (sums_outstanding),
        .cells_seen       (cells_seen)
    );

    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 5);
            if (holds_served != holds_asked) begin
                stall = HOLD_CYCLES;
                holds_served++;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    function automatic int dim_used(input logic [DIM_W-1:0] d);
        return (d > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    function automatic logic [ELEM_BITS-1:0] pick_element();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(ELEM_BITS - 1){1'b0}}};
            1:       return {1'b0, {(ELEM_BITS - 1){1'b1}}};
            2:       return '0;
            default: return ELEM_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return '0;
        if (roll == 1) return DIM_W'($urandom_range(MAX_DIM + 1, 15));
        if (roll < 5) return DIM_W'(MAX_DIM);
        return DIM_W'($urandom_range(1, MAX_DIM));
    endfunction

    function automatic cfg_t random_setting();
        cfg_t next;
        next.a_tr      = 1'($urandom_range(0, 1));
        next.b_tr      = 1'($urandom_range(0, 1));
        next.out_rows  = pick_dim();
        next.out_cols  = pick_dim();
        next.inner_len = pick_dim();
        next.a_row_len = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 15))
                       : (next.a_tr ? next.out_rows : next.inner_len);
        next.b_row_len = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 15))
                       : (next.b_tr ? next.inner_len : next.out_cols);
        return next;
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] pos,
                             input logic [ELEM_BITS-1:0] elem);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({elem, pos, cmd});
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (cmd == CMD_LOAD_A) begin
            a_loaded[pos] = 1'b1;
            loads_sent++;
        end else if (cmd == CMD_LOAD_B) begin
            b_loaded[pos] = 1'b1;
            loads_sent++;
        end else if (cmd == CMD_COMPUTE) begin
            computes_sent++;
        end
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 1))
            send_item(CMD_UNUSED, ADDR_W'($urandom), ELEM_BITS'($urandom));
        else
            send_item($urandom_range(0, 1) ? CMD_LOAD_A : CMD_LOAD_B, ADDR_W'($urandom),
                      pick_element());
    endtask

    // Loads every entry the next compute reads that is still unwritten, or all of
    // them when refresh is set, so that no compute reads an entry never loaded.
    task automatic load_operands(input bit refresh, input bit noisy);
        int                     rows;
        int                     cols;
        int                     depth;
        int                     at;
        logic [STORE_DEPTH-1:0] a_done;
        logic [STORE_DEPTH-1:0] b_done;
        rows   = dim_used(setting.out_rows);
        cols   = dim_used(setting.out_cols);
        depth  = dim_used(setting.inner_len);
        a_done = '0;
        b_done = '0;
        for (int r = 0; r < rows; r++) begin
            for (int k = 0; k < depth; k++) begin
                at = (setting.a_tr ? k * setting.a_row_len + r : r * setting.a_row_len + k)
                     & (STORE_DEPTH - 1);
                if (!a_done[at] && (refresh || !a_loaded[at])) begin
                    if (noisy && $urandom_range(0, 7) == 0) send_noise();
                    send_item(CMD_LOAD_A, ADDR_W'(at), pick_element());
                end
                a_done[at] = 1'b1;
            end
        end
        for (int k = 0; k < depth; k++) begin
            for (int c = 0; c < cols; c++) begin
                at = (setting.b_tr ? c * setting.b_row_len + k : k * setting.b_row_len + c)
                     & (STORE_DEPTH - 1);
                if (!b_done[at] && (refresh || !b_loaded[at])) begin
                    if (noisy && $urandom_range(0, 7) == 0) send_noise();
                    send_item(CMD_LOAD_B, ADDR_W'(at), pick_element());
                end
                b_done[at] = 1'b1;
            end
        end
    endtask

    task automatic send_compute();
        send_item(CMD_COMPUTE, ADDR_W'($urandom), ELEM_BITS'($urandom));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sums_outstanding != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
    endtask

    task automatic apply_setting(input cfg_t next);
        wait_idle();
        write_reg(CFG_A_TR, (CFG_DATA_W'($urandom_range(0, 7)) << 1) | CFG_DATA_W'(next.a_tr));
        write_reg(CFG_B_TR, (CFG_DATA_W'($urandom_range(0, 7)) << 1) | CFG_DATA_W'(next.b_tr));
        write_reg(CFG_OUT_ROWS, next.out_rows);
        write_reg(CFG_OUT_COLS, next.out_cols);
        write_reg(CFG_INNER_LEN, next.inner_len);
        write_reg(CFG_A_ROW_LEN, next.a_row_len);
        write_reg(CFG_B_ROW_LEN, next.b_row_len);
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        setting = next;
        settings_used++;
    endtask

    initial begin : stimulus
        cfg_t next;
        int   target;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Largest magnitudes in a one-cell product, the unused command, the top
        // store position, and position and element ignored on compute.
        send_item(CMD_LOAD_A, '0, {1'b1, {(ELEM_BITS - 1){1'b0}}});
        send_item(CMD_LOAD_B, '0, {1'b1, {(ELEM_BITS - 1){1'b0}}});
        send_item(CMD_COMPUTE, '0, '0);
        send_item(CMD_UNUSED, '1, '1);
        send_item(CMD_LOAD_A, '1, {1'b0, {(ELEM_BITS - 1){1'b1}}});
        send_item(CMD_LOAD_A, '0, {1'b0, {(ELEM_BITS - 1){1'b1}}});
        send_item(CMD_COMPUTE, '1, '1);

        // No rows gives no result; an empty inner sum gives a zero cell.
        apply_setting('{a_tr: 1'b0, b_tr: 1'b0, out_rows: DIM_W'(0), out_cols: DIM_W'(1),
                        inner_len: DIM_W'(1), a_row_len: DIM_W'(1), b_row_len: DIM_W'(1)});
        send_compute();
        apply_setting('{a_tr: 1'b0, b_tr: 1'b0, out_rows: DIM_W'(1), out_cols: DIM_W'(1),
                        inner_len: DIM_W'(0), a_row_len: DIM_W'(1), b_row_len: DIM_W'(1)});
        send_compute();

        // Oversized row count clamps to eight, and a long stored row wraps addresses.
        apply_setting('{a_tr: 1'b0, b_tr: 1'b1, out_rows: DIM_W'(15), out_cols: DIM_W'(1),
                        inner_len: DIM_W'(1), a_row_len: DIM_W'(15), b_row_len: DIM_W'(15)});
        load_operands(1'b0, 1'b0);
        send_compute();

        apply_setting('{a_tr: 1'b1, b_tr: 1'b0, out_rows: DIM_W'(2), out_cols: DIM_W'(2),
                        inner_len: DIM_W'(2), a_row_len: DIM_W'(2), b_row_len: DIM_W'(2)});
        load_operands(1'b0, 1'b0);
        send_compute();

        // Full size with the result side held off while computes keep coming.
        target = loads_sent + computes_sent + RANDOM_ITEMS;
        apply_setting('{a_tr: 1'b0, b_tr: 1'b0, out_rows: DIM_W'(MAX_DIM),
                        out_cols: DIM_W'(MAX_DIM), inner_len: DIM_W'(MAX_DIM),
                        a_row_len: DIM_W'(MAX_DIM), b_row_len: DIM_W'(MAX_DIM)});
        load_operands(1'b1, 1'b1);
        tx_steady = 1'b1;
        holds_asked++;
        repeat (3) send_compute();

        while (loads_sent + computes_sent < target) begin
            next = random_setting();
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            apply_setting(next);
            load_operands($urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0);
            send_compute();
            if ($urandom_range(0, 2) == 0) begin
                load_operands(1'b1, 1'b0);
                send_compute();
            end
        end

        wait_idle();
        $display("Run covered %0d load items and %0d compute items over %0d register settings,",
                 loads_sent, computes_sent, settings_used);
        $display("with %0d cell results checked and one %0d-cycle hold on the result side.",
                 cells_seen, HOLD_CYCLES);
        if (mismatches == 0 && sums_outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
